// ===== rtl/core/lspa_pkg.sv =====
// Package for the linked slot pool allocator.
// Holds the request and response word types, the codes, the controller states and the command and status structs.
// No dependencies.
`default_nettype none

package lspa_pkg;

   localparam logic [1:0] REQ_ALLOCATE = 2'd0;
   localparam logic [1:0] REQ_RELEASE  = 2'd1;
   localparam logic [1:0] REQ_SEARCH   = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [4:0]  slot_index;
      logic [15:0] search_key;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  result_slot;
      logic [15:0] result_seq;
   } rsp_word_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_ALLOC_WRITE,
      S_WALK_FIRST,
      S_WALK,
      S_REL_UNLINK,
      S_REL_PUSH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       alloc_read;
      logic       alloc_write;
      logic       walk_first;
      logic       walk_step;
      logic       rel_unlink;
      logic       rel_push;
      logic       rsp_load;
      logic       rsp_alloc;
      logic [1:0] rsp_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] req_type;
      logic       target_bad;
      logic       free_empty;
      logic       walk_null;
      logic       rel_hit;
      logic       srch_hit;
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/linked_slot_pool_allocator.sv =====
// Top level of the linked slot pool allocator.
// Depends on lspa_pkg, lspa_ctrl and lspa_datapath.
//
//   Channel   Ports                       Handshake
//   request   start, busy, req_word       word taken at an edge with start high, busy low
//   response  rsp_strobe, rsp_word        word valid for one cycle, no back pressure
//
// Release and search walk the active list one entry per cycle through the registered
// read port of the link memory; unknown request types and early rejects are answered
// from the decode state. Reset is synchronous and active high and leaves the whole
// pool on the free list, with no clearing pass. The receiver cannot stall: a new word
// may be accepted in the strobe cycle of the previous response.
`default_nettype none

module linked_slot_pool_allocator #(
   parameter int POOL_SLOTS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire lspa_pkg::req_word_type req_word,
   output logic                        rsp_strobe,
   output lspa_pkg::rsp_word_type      rsp_word
);

   lspa_pkg::cmd_type  cmd;
   lspa_pkg::stat_type stat;

   // The controller sequences allocate, walk, unlink and push steps.
   lspa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // The datapath owns both lists, the memories and the response register.
   lspa_datapath #(
      .POOL_SLOTS (POOL_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

`default_nettype wire

// ===== rtl/core/lspa_ctrl.sv =====
// Controller state machine of the linked slot pool allocator.
// Depends on lspa_pkg; drives the datapath through command and status structs.
`default_nettype none

module lspa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire lspa_pkg::stat_type stat,
   output lspa_pkg::cmd_type      cmd
);

   lspa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lspa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != lspa_pkg::S_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lspa_pkg::S_IDLE: begin
            if (start) state_in = lspa_pkg::S_DECODE;
         end
         lspa_pkg::S_DECODE: begin
            case (stat.req_type)
               lspa_pkg::REQ_ALLOCATE: begin
                  state_in = stat.free_empty ? lspa_pkg::S_IDLE : lspa_pkg::S_ALLOC_WRITE;
               end
               lspa_pkg::REQ_RELEASE: begin
                  state_in = stat.target_bad ? lspa_pkg::S_IDLE : lspa_pkg::S_WALK_FIRST;
               end
               lspa_pkg::REQ_SEARCH: begin
                  state_in = lspa_pkg::S_WALK_FIRST;
               end
               default: begin
                  state_in = lspa_pkg::S_IDLE;
               end
            endcase
         end
         lspa_pkg::S_ALLOC_WRITE: begin
            state_in = lspa_pkg::S_IDLE;
         end
         lspa_pkg::S_WALK_FIRST, lspa_pkg::S_WALK: begin
            if (stat.req_type == lspa_pkg::REQ_SEARCH) begin
               if ((state_ff == lspa_pkg::S_WALK && stat.srch_hit) || stat.walk_null) begin
                  state_in = lspa_pkg::S_IDLE;
               end else begin
                  state_in = lspa_pkg::S_WALK;
               end
            end else begin
               if (stat.walk_null) begin
                  state_in = lspa_pkg::S_IDLE;
               end else if (stat.rel_hit) begin
                  state_in = lspa_pkg::S_REL_UNLINK;
               end else begin
                  state_in = lspa_pkg::S_WALK;
               end
            end
         end
         lspa_pkg::S_REL_UNLINK: begin
            state_in = lspa_pkg::S_REL_PUSH;
         end
         lspa_pkg::S_REL_PUSH: begin
            state_in = lspa_pkg::S_IDLE;
         end
         default: begin
            state_in = lspa_pkg::S_IDLE;
         end
      endcase
   end

   // Commands.
   always_comb begin
      cmd = '0;
      cmd.rsp_status = lspa_pkg::ST_NOT_FOUND;
      case (state_ff)
         lspa_pkg::S_IDLE: begin
            cmd.capture = start;
         end
         lspa_pkg::S_DECODE: begin
            case (stat.req_type)
               lspa_pkg::REQ_ALLOCATE: begin
                  if (stat.free_empty) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = lspa_pkg::ST_EXHAUSTED;
                  end else begin
                     cmd.alloc_read = 1'b1;
                  end
               end
               lspa_pkg::REQ_RELEASE: begin
                  cmd.rsp_load = stat.target_bad;
               end
               lspa_pkg::REQ_SEARCH: begin
                  cmd.rsp_load = 1'b0;
               end
               default: begin
                  cmd.rsp_load = 1'b1;
               end
            endcase
         end
         lspa_pkg::S_ALLOC_WRITE: begin
            cmd.alloc_write = 1'b1;
            cmd.rsp_load    = 1'b1;
            cmd.rsp_alloc   = 1'b1;
            cmd.rsp_status  = lspa_pkg::ST_OK;
         end
         lspa_pkg::S_WALK_FIRST, lspa_pkg::S_WALK: begin
            cmd.walk_first = (state_ff == lspa_pkg::S_WALK_FIRST);
            if (stat.req_type == lspa_pkg::REQ_SEARCH) begin
               if (state_ff == lspa_pkg::S_WALK && stat.srch_hit) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = lspa_pkg::ST_OK;
               end else if (stat.walk_null) begin
                  cmd.rsp_load = 1'b1;
               end else begin
                  cmd.walk_step = 1'b1;
               end
            end else begin
               if (stat.walk_null) begin
                  cmd.rsp_load = 1'b1;
               end else begin
                  cmd.walk_step = 1'b1;
               end
            end
         end
         lspa_pkg::S_REL_UNLINK: begin
            cmd.rel_unlink = 1'b1;
         end
         lspa_pkg::S_REL_PUSH: begin
            cmd.rel_push   = 1'b1;
            cmd.rsp_load   = 1'b1;
            cmd.rsp_status = lspa_pkg::ST_OK;
         end
         default: begin
            cmd.rsp_load = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/lspa_datapath.sv =====
// Datapath of the linked slot pool allocator: list heads, link and sequence memories,
// walk registers and the response register. Depends on lspa_pkg.
`default_nettype none

module lspa_datapath #(
   parameter int POOL_SLOTS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lspa_pkg::req_word_type req_word,
   input  wire lspa_pkg::cmd_type     cmd,
   output lspa_pkg::stat_type         stat,
   output logic                       rsp_strobe,
   output lspa_pkg::rsp_word_type     rsp_word
);

   localparam int LW = $clog2(POOL_SLOTS + 1);
   localparam int IW = $clog2(POOL_SLOTS);
   localparam logic [LW-1:0] NULL_LINK = LW'(POOL_SLOTS);

   logic [LW-1:0] link_mem [POOL_SLOTS];
   logic [15:0]   seq_mem  [POOL_SLOTS];
   logic [POOL_SLOTS-1:0] link_valid_ff;

   lspa_pkg::req_word_type req_ff;
   logic [LW-1:0] active_head_ff, free_head_ff;
   logic [LW-1:0] cur_ff, prev_ff;
   logic [LW-1:0] link_rd_ff, link_addr_ff;
   logic          link_vrd_ff;
   logic [15:0]   seq_rd_ff;
   logic          rsp_strobe_ff;
   lspa_pkg::rsp_word_type rsp_word_ff;

   logic [LW-1:0] link_val, cur_c, target;
   logic          link_re, seq_re;
   logic [IW-1:0] link_ra, seq_ra;
   logic [15:0]   new_seq;
   logic          active_null;

   // An entry never written still holds its reset link, the next slot.
   assign link_val    = link_vrd_ff ? link_rd_ff : link_addr_ff + LW'(1);
   assign cur_c       = cmd.walk_first ? active_head_ff : link_val;
   assign target      = LW'(req_ff.slot_index);
   assign active_null = (active_head_ff == NULL_LINK);
   assign new_seq     = active_null ? 16'd0 : seq_rd_ff + 16'd1;

   assign stat.req_type   = req_ff.req_type;
   assign stat.target_bad = (32'(req_ff.slot_index) >= 32'(POOL_SLOTS));
   assign stat.free_empty = (free_head_ff == NULL_LINK);
   assign stat.walk_null  = (cur_c == NULL_LINK);
   assign stat.rel_hit    = (cur_c == target);
   assign stat.srch_hit   = (seq_rd_ff == req_ff.search_key);

   always_comb begin
      link_re = cmd.alloc_read | cmd.walk_step;
      seq_re  = cmd.alloc_read | cmd.walk_step;
      link_ra = cmd.alloc_read ? free_head_ff[IW-1:0] : cur_c[IW-1:0];
      if (cmd.alloc_read) begin
         seq_ra = active_null ? '0 : active_head_ff[IW-1:0];
      end else begin
         seq_ra = cur_c[IW-1:0];
      end
   end

   // Link memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.alloc_write) begin
         link_mem[free_head_ff[IW-1:0]] <= active_head_ff;
      end else if (cmd.rel_unlink && prev_ff != NULL_LINK) begin
         link_mem[prev_ff[IW-1:0]] <= link_val;
      end else if (cmd.rel_push) begin
         link_mem[cur_ff[IW-1:0]] <= free_head_ff;
      end
      if (link_re) begin
         link_rd_ff   <= link_mem[link_ra];
         link_addr_ff <= {{(LW-IW){1'b0}}, link_ra};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_valid_ff <= '0;
         link_vrd_ff   <= 1'b0;
      end else begin
         if (cmd.alloc_write) begin
            link_valid_ff[free_head_ff[IW-1:0]] <= 1'b1;
         end else if (cmd.rel_unlink && prev_ff != NULL_LINK) begin
            link_valid_ff[prev_ff[IW-1:0]] <= 1'b1;
         end else if (cmd.rel_push) begin
            link_valid_ff[cur_ff[IW-1:0]] <= 1'b1;
         end
         if (link_re) begin
            link_vrd_ff <= link_valid_ff[link_ra];
         end
      end
   end

   // Sequence memory: written on allocation only.
   always_ff @(posedge clock) begin
      if (cmd.alloc_write) begin
         seq_mem[free_head_ff[IW-1:0]] <= new_seq;
      end
      if (seq_re) begin
         seq_rd_ff <= seq_mem[seq_ra];
      end
   end

   // List heads.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_head_ff <= NULL_LINK;
         free_head_ff   <= '0;
      end else begin
         if (cmd.alloc_write) begin
            active_head_ff <= free_head_ff;
            free_head_ff   <= link_val;
         end else if (cmd.rel_unlink && prev_ff == NULL_LINK) begin
            active_head_ff <= link_val;
         end else if (cmd.rel_push) begin
            free_head_ff <= cur_ff;
         end
      end
   end

   // Request capture and walk position.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_word;
      end
      if (cmd.walk_step) begin
         cur_ff  <= cur_c;
         prev_ff <= cmd.walk_first ? NULL_LINK : cur_ff;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_word_ff.status <= cmd.rsp_status;
         if (cmd.rsp_status != lspa_pkg::ST_OK) begin
            rsp_word_ff.result_slot <= 5'd0;
            rsp_word_ff.result_seq  <= 16'd0;
         end else if (cmd.rsp_alloc) begin
            rsp_word_ff.result_slot <= 5'(free_head_ff);
            rsp_word_ff.result_seq  <= new_seq;
         end else begin
            rsp_word_ff.result_slot <= 5'(cur_ff);
            rsp_word_ff.result_seq  <= seq_rd_ff;
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lspa_checker.sv =====
// Port-level checks for the linked slot pool allocator, bound to the top level.
// Depends on lspa_pkg.
`default_nettype none

module lspa_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire logic                   rsp_strobe,
   input wire lspa_pkg::rsp_word_type rsp_word
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not make the block busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.status == lspa_pkg::ST_OK ||
                      rsp_word.status == lspa_pkg::ST_EXHAUSTED ||
                      rsp_word.status == lspa_pkg::ST_NOT_FOUND))
      else $error("response carries an unknown status");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status != lspa_pkg::ST_OK) |->
         (rsp_word.result_slot == 5'd0 && rsp_word.result_seq == 16'd0))
      else $error("failed response carries nonzero fields");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two responses in consecutive cycles");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_strobe) |-> $past(busy))
      else $error("response without a request in progress");

endmodule

bind linked_slot_pool_allocator lspa_checker u_lspa_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for linked_slot_pool_allocator: allocate, release and search words
// are checked against a behavioral copy of the free and active slot lists.
// Depends on lspa_pkg and the allocator RTL only.

module tb;

   localparam int POOL_SLOTS = 32;
   // The list terminator, encoded one past the last slot as in the block.
   localparam logic [5:0] NULL_LINK = 6'(POOL_SLOTS);
   // The request code that names no operation.
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   // Longest quiet stretch of a correct run is a sender gap plus a full list walk;
   // this limit leaves a wide margin over it.
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_REPORTED = 10;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   lspa_pkg::req_word_type req_word;
   logic                   rsp_strobe;
   lspa_pkg::rsp_word_type rsp_word;

   // Behavioral copy of the pool: one shared next-link store, two list heads and the
   // sequence number of every slot.
   logic [5:0]   next_link [POOL_SLOTS];
   logic [15:0]  slot_seq [POOL_SLOTS];
   logic [5:0]   active_head;
   logic [5:0]   free_head;

   // Responses still owed by the block, oldest first.
   lspa_pkg::rsp_word_type pending_rsp_q[$];
   int           error_count = 0;
   int           rsp_count = 0;
   int           send_idle_pct = 0;

   linked_slot_pool_allocator #(
      .POOL_SLOTS(POOL_SLOTS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always #4 clock = ~clock;

   // Applies one request word to the pool copy and returns the response it must cause.
   function automatic lspa_pkg::rsp_word_type pool_apply(input lspa_pkg::req_word_type w);
      lspa_pkg::rsp_word_type r;
      logic [5:0]   cur;
      logic [5:0]   prev;
      int           steps;
      r = '0;
      r.status = lspa_pkg::ST_NOT_FOUND;
      case (w.req_type)
         lspa_pkg::REQ_ALLOCATE: begin
            if (free_head == NULL_LINK) begin
               r.status = lspa_pkg::ST_EXHAUSTED;
            end else begin
               cur = free_head;
               free_head = next_link[cur];
               // A fresh list restarts numbering; otherwise count on from the newest entry.
               slot_seq[cur] = (active_head == NULL_LINK) ? 16'd0
                                                          : slot_seq[active_head] + 16'd1;
               next_link[cur] = active_head;
               active_head = cur;
               r.status = lspa_pkg::ST_OK;
               r.result_slot = cur[4:0];
               r.result_seq = slot_seq[cur];
            end
         end
         lspa_pkg::REQ_RELEASE: begin
            cur = active_head;
            prev = NULL_LINK;
            steps = 0;
            if (int'(w.slot_index) < POOL_SLOTS) begin
               while (cur != NULL_LINK && cur != {1'b0, w.slot_index}
                      && steps < POOL_SLOTS) begin
                  prev = cur;
                  cur = next_link[cur];
                  steps++;
               end
               if (cur == {1'b0, w.slot_index}) begin
                  if (prev == NULL_LINK) begin
                     active_head = next_link[cur];
                  end else begin
                     next_link[prev] = next_link[cur];
                  end
                  next_link[cur] = free_head;
                  free_head = cur;
                  r.status = lspa_pkg::ST_OK;
                  r.result_slot = cur[4:0];
                  r.result_seq = slot_seq[cur];
               end
            end
         end
         lspa_pkg::REQ_SEARCH: begin
            cur = active_head;
            steps = 0;
            while (cur != NULL_LINK && steps < POOL_SLOTS
                   && r.status != lspa_pkg::ST_OK) begin
               if (slot_seq[cur] == w.search_key) begin
                  r.status = lspa_pkg::ST_OK;
                  r.result_slot = cur[4:0];
                  r.result_seq = slot_seq[cur];
               end
               cur = next_link[cur];
               steps++;
            end
         end
         default: begin
            // The unused request code changes nothing and reports not found.
         end
      endcase
      return r;
   endfunction

   // Picks an active slot at random, or returns the null link when the list is empty.
   function automatic logic [5:0] pick_active_slot();
      logic [5:0] cur;
      int         count;
      int         pick;
      count = 0;
      cur = active_head;
      while (cur != NULL_LINK) begin
         count++;
         cur = next_link[cur];
      end
      if (count == 0) begin
         return NULL_LINK;
      end
      pick = $urandom_range(count - 1);
      cur = active_head;
      repeat (pick) cur = next_link[cur];
      return cur;
   endfunction

   // Builds a word with the given fields; pass random values for fields the request ignores.
   function automatic lspa_pkg::req_word_type make_word(input logic [1:0] kind,
                                                        input logic [4:0] slot,
                                                        input logic [15:0] key);
      lspa_pkg::req_word_type w;
      w.req_type = kind;
      w.slot_index = slot;
      w.search_key = key;
      return w;
   endfunction

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTED) begin
         $display("%s", msg);
      end
   endfunction

   // Sends one word. Start stays high from one word to the next unless the sender decides
   // to idle first, so start never gets two updates in one time step. The word is taken
   // at the first edge where busy is low; the expected response is queued right there,
   // before the block can strobe it.
   task automatic send_word(input lspa_pkg::req_word_type w);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, POOL_SLOTS + 8)) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      pending_rsp_q.push_back(pool_apply(w));
   endtask

   // Holds the sender off until every owed response has come back. Always waits for a
   // clock edge, so a following send never meets the lowered start in the same step.
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_rsp_q.size() != 0);
   endtask

   // Extremes and special cases, starting from the reset state of the pool.
   task automatic test_directed();
      send_idle_pct = 0;
      // Search an empty list, release from an empty list, then the unused request code.
      send_word(make_word(lspa_pkg::REQ_SEARCH, 5'd0, 16'd0));
      send_word(make_word(lspa_pkg::REQ_RELEASE, 5'd0, 16'd0));
      send_word(make_word(REQ_UNUSED, 5'd31, 16'hFFFF));
      // Ignored fields all ones.
      send_word(make_word(lspa_pkg::REQ_ALLOCATE, 5'd31, 16'hFFFF));
      send_word(make_word(lspa_pkg::REQ_ALLOCATE, 5'd0, 16'd0));
      send_word(make_word(lspa_pkg::REQ_ALLOCATE, 5'd10, 16'h5A5A));
      send_word(make_word(lspa_pkg::REQ_ALLOCATE, 5'd21, 16'hA5A5));
      // Match at the tail, match at the head, no match.
      send_word(make_word(lspa_pkg::REQ_SEARCH, 5'd31, 16'd0));
      send_word(make_word(lspa_pkg::REQ_SEARCH, 5'd0, 16'd3));
      send_word(make_word(lspa_pkg::REQ_SEARCH, 5'd0, 16'hFFFF));
      // Unlink from the middle, then a slot no longer active, then one never allocated.
      send_word(make_word(lspa_pkg::REQ_RELEASE, 5'd1, 16'hFFFF));
      send_word(make_word(lspa_pkg::REQ_RELEASE, 5'd1, 16'd0));
      send_word(make_word(lspa_pkg::REQ_RELEASE, 5'd31, 16'd0));
      // Unlink the head, reuse a freed slot, unlink the tail.
      send_word(make_word(lspa_pkg::REQ_RELEASE, 5'd3, 16'd0));
      send_word(make_word(lspa_pkg::REQ_ALLOCATE, 5'd0, 16'd0));
      send_word(make_word(lspa_pkg::REQ_RELEASE, 5'd0, 16'd0));
      // Number of a released slot.
      send_word(make_word(lspa_pkg::REQ_SEARCH, 5'd0, 16'd1));
      send_word(make_word(REQ_UNUSED, 5'd0, 16'd0));
      send_word(make_word(lspa_pkg::REQ_RELEASE, 5'd3, 16'd0));
      // The list is empty again, so numbering restarts at zero.
      send_word(make_word(lspa_pkg::REQ_RELEASE, 5'd2, 16'd0));
      send_word(make_word(lspa_pkg::REQ_ALLOCATE, 5'd0, 16'd0));
      send_word(make_word(lspa_pkg::REQ_SEARCH, 5'd0, 16'd0));
   endtask

   // Fills the pool completely, then exercises the longest walks on a full active list.
   task automatic test_pool_exhaustion();
      logic [5:0] tail;
      send_idle_pct = 0;
      while (free_head != NULL_LINK) begin
         send_word(make_word(lspa_pkg::REQ_ALLOCATE, 5'($urandom), 16'($urandom)));
      end
      // Pool exhausted, twice.
      send_word(make_word(lspa_pkg::REQ_ALLOCATE, 5'd0, 16'd0));
      send_word(make_word(lspa_pkg::REQ_ALLOCATE, 5'd31, 16'hFFFF));
      tail = active_head;
      while (next_link[tail] != NULL_LINK) tail = next_link[tail];
      // Deepest hit, full walk with no hit, deepest unlink.
      send_word(make_word(lspa_pkg::REQ_SEARCH, 5'd0, slot_seq[tail]));
      send_word(make_word(lspa_pkg::REQ_SEARCH, 5'd0, 16'hFFFF));
      send_word(make_word(lspa_pkg::REQ_RELEASE, tail[4:0], 16'd0));
      send_word(make_word(lspa_pkg::REQ_ALLOCATE, 5'd0, 16'd0));
      send_word(make_word(lspa_pkg::REQ_RELEASE, active_head[4:0], 16'd0));
   endtask

   // Mostly well-formed traffic: releases and searches aimed at active slots, with the
   // allocate share shifting now and then so the pool swings between empty and full.
   // The rest is noise: stray releases, random keys and the unused request code.
   task automatic test_random_traffic(input int n_items, input int idle_pct);
      lspa_pkg::req_word_type w;
      logic [5:0]   s;
      int           alloc_pct;
      int           roll;
      send_idle_pct = idle_pct;
      alloc_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (i % 25 == 0) begin
            alloc_pct = $urandom_range(10, 80);
         end
         // Once per run the sender waits for the block to go completely quiet.
         if (i == n_items / 2) begin
            wait_for_drain();
         end
         w = make_word(lspa_pkg::REQ_ALLOCATE, 5'($urandom), 16'($urandom));
         roll = $urandom_range(99);
         if (roll >= alloc_pct) begin
            roll = $urandom_range(99);
            s = pick_active_slot();
            if (roll < 45) begin
               w.req_type = lspa_pkg::REQ_RELEASE;
               if (s != NULL_LINK) begin
                  w.slot_index = s[4:0];
               end
            end else if (roll < 65) begin
               w.req_type = lspa_pkg::REQ_SEARCH;
               if (s != NULL_LINK) begin
                  w.search_key = slot_seq[s];
               end
            end else if (roll < 80) begin
               w.req_type = lspa_pkg::REQ_RELEASE;
            end else if (roll < 93) begin
               w.req_type = lspa_pkg::REQ_SEARCH;
            end else begin
               w.req_type = REQ_UNUSED;
            end
         end
         send_word(w);
      end
   endtask

   // Response checker. The strobe and word are sampled at the edge that ends their cycle;
   // each response is matched against the oldest owed one, field by field.
   always @(posedge clock) begin : rsp_check
      lspa_pkg::rsp_word_type want;
      if (!reset && rsp_strobe) begin
         rsp_count++;
         if (pending_rsp_q.size() == 0) begin
            note_error($sformatf({"ERROR: response %0d arrived with none owed:",
                                  " status %0d slot %0d seq %0d"},
                                 rsp_count, rsp_word.status, rsp_word.result_slot,
                                 rsp_word.result_seq));
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_word.status !== want.status || rsp_word.result_slot !== want.result_slot
                || rsp_word.result_seq !== want.result_seq) begin
               note_error($sformatf({"ERROR: response %0d: expected status %0d slot %0d",
                                     " seq %0d, got status %0d slot %0d seq %0d"},
                                    rsp_count, want.status, want.result_slot,
                                    want.result_seq, rsp_word.status,
                                    rsp_word.result_slot, rsp_word.result_seq));
            end
         end
      end
   end

   // Watchdog: ends the run when neither a request word nor a response word has moved
   // for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("ERROR: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : main
      // Every block input is known from time zero; the pool copy starts in its reset state.
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      for (int i = 0; i < POOL_SLOTS; i++) begin
         next_link[i] = 6'(i + 1);
         slot_seq[i] = '0;
      end
      active_head = NULL_LINK;
      free_head = 6'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_pool_exhaustion();
      test_random_traffic(130, 24);
      test_random_traffic(130, 54);
      test_random_traffic(130, 0);

      // Collect every owed response, then watch long enough for a full walk to show
      // any stray strobe.
      wait_for_drain();
      repeat (POOL_SLOTS + 8) @(posedge clock);
      if (error_count == 0 && pending_rsp_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
